/* rtl/lis_length_patience_sort_assert.svh */
// assertion macros used by lis_length_patience_sort.sv
`ifndef LIS_LENGTH_PATIENCE_SORT_ASSERT_SVH
`define LIS_LENGTH_PATIENCE_SORT_ASSERT_SVH

// same-cycle implication, held off during reset
`define LPS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, held off during reset
`define LPS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/lps_pkg.sv */
`timescale 1ns / 1ps

package lps_pkg;

  localparam int MaxLenDefault = 1024;
  localparam int ValueW        = 32;
  localparam int LisLenW       = 11;

  typedef struct packed {
    logic signed [ValueW-1:0] value;
    logic                     last_item;
  } in_item_t;

  typedef struct packed {
    logic [LisLenW-1:0] lis_length;
    logic               overflow;
    logic               is_last;
  } out_item_t;

endpackage

/* rtl/lps_tail_ram.sv */
`timescale 1ns / 1ps

module lps_tail_ram #(
  parameter int Depth = lps_pkg::MaxLenDefault
) (
  input  logic                                  clk_i,
  input  logic                                  we_i,
  input  logic [$clog2(Depth)-1:0]              addr_i,
  input  logic [lps_pkg::ValueW-1:0]            wdata_i,
  output logic [lps_pkg::ValueW-1:0]            rdata_o
);

  logic [lps_pkg::ValueW-1:0] mem [Depth];
  logic [lps_pkg::ValueW-1:0] rdata_q;

  // single port, registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/lps_ctrl.sv */
`timescale 1ns / 1ps

module lps_ctrl #(
  parameter int MaxLen = lps_pkg::MaxLenDefault
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  lps_pkg::in_item_t                    in_item_i,
  output logic                                 res_valid_o,
  input  logic                                 res_busy_i,
  output lps_pkg::out_item_t                   res_o,
  output logic                                 ram_we_o,
  output logic [$clog2(MaxLen)-1:0]            ram_addr_o,
  output logic [lps_pkg::ValueW-1:0]           ram_wdata_o,
  input  logic [lps_pkg::ValueW-1:0]           ram_rdata_i
);

  localparam int AddrW = $clog2(MaxLen);
  localparam int CntW  = $clog2(MaxLen + 1);

  localparam logic [1:0] StIdle   = 2'd0;
  localparam logic [1:0] StTop    = 2'd1;
  localparam logic [1:0] StSearch = 2'd2;
  localparam logic [1:0] StResult = 2'd3;

  logic [1:0]                 state_q, state_d;
  logic [CntW-1:0]            cnt_q, cnt_d;
  logic                       ovf_q, ovf_d;
  logic [AddrW-1:0]           lo_q, lo_d, hi_q, hi_d, mid_q, mid_d;
  logic [lps_pkg::ValueW-1:0] val_q, val_d;
  logic                       last_q, last_d;

  logic                       rd_less;
  logic [AddrW-1:0]           lo_n, hi_n, mid_n, top_idx;

  // signed order as an unsigned compare of sign-flipped keys
  assign rd_less = (ram_rdata_i ^ {1'b1, {(lps_pkg::ValueW-1){1'b0}}})
                 < (val_q ^ {1'b1, {(lps_pkg::ValueW-1){1'b0}}});

  assign top_idx = AddrW'(cnt_q - CntW'(1));

  // one bisection step on the entry read last cycle
  always_comb begin
    if (rd_less) begin
      lo_n = mid_q + AddrW'(1);
      hi_n = hi_q;
    end else begin
      lo_n = lo_q;
      hi_n = mid_q;
    end
    mid_n = lo_n + ((hi_n - lo_n) >> 1);
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    ovf_d       = ovf_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    mid_d       = mid_q;
    val_d       = val_q;
    last_d      = last_q;
    in_stall_o  = 1'b1;
    res_valid_o = 1'b0;
    ram_we_o    = 1'b0;
    ram_addr_o  = mid_q;
    ram_wdata_o = val_q;

    unique case (state_q)
      StIdle: begin
        in_stall_o = 1'b0;
        ram_addr_o = top_idx;
        if (in_valid_i) begin
          val_d  = in_item_i.value;
          last_d = in_item_i.last_item;
          if (cnt_q == '0) begin
            // empty store: first tail goes straight in
            ram_we_o    = 1'b1;
            ram_addr_o  = '0;
            ram_wdata_o = in_item_i.value;
            cnt_d       = CntW'(1);
            state_d     = StResult;
          end else begin
            state_d = StTop;
          end
        end
      end
      StTop: begin
        if (rd_less) begin
          if (cnt_q < CntW'(MaxLen)) begin
            ram_we_o   = 1'b1;
            ram_addr_o = AddrW'(cnt_q);
            cnt_d      = cnt_q + CntW'(1);
          end else begin
            ovf_d = 1'b1;
          end
          state_d = StResult;
        end else if (top_idx == '0) begin
          ram_we_o   = 1'b1;
          ram_addr_o = '0;
          state_d    = StResult;
        end else begin
          // lower bound lies in [0, top]
          lo_d       = '0;
          hi_d       = top_idx;
          mid_d      = top_idx >> 1;
          ram_addr_o = top_idx >> 1;
          state_d    = StSearch;
        end
      end
      StSearch: begin
        lo_d = lo_n;
        hi_d = hi_n;
        if (lo_n < hi_n) begin
          mid_d      = mid_n;
          ram_addr_o = mid_n;
        end else begin
          ram_we_o   = 1'b1;
          ram_addr_o = lo_n;
          state_d    = StResult;
        end
      end
      StResult: begin
        res_valid_o = 1'b1;
        if (!res_busy_i) begin
          state_d = StIdle;
          if (last_q) begin
            cnt_d = '0;
            ovf_d = 1'b0;
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end

  assign res_o.lis_length = lps_pkg::LisLenW'(cnt_q);
  assign res_o.overflow   = ovf_q;
  assign res_o.is_last    = last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q   <= '0;
      ovf_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      ovf_q   <= ovf_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q   <= lo_d;
    hi_q   <= hi_d;
    mid_q  <= mid_d;
    val_q  <= val_d;
    last_q <= last_d;
  end

endmodule

/* rtl/lis_length_patience_sort.sv */
`timescale 1ns / 1ps

// channel | direction | handshake             | payload
// in      | input     | in_valid_i/in_stall_o | in_item_i   (value, last_item)
// out     | output    | out_valid_o/out_stall_i | out_item_o (lis_length, overflow, is_last)
//
// one item at a time: an empty store takes the value straight in, an append or a
// replace of entry zero needs only a read of the top entry, and any other value runs a
// lower-bound search, one tail ram read per bisection step
// reset clears the tail count and overflow flag; the ram needs no clearing
// the next item is taken while a finished result waits in the output register;
// a stalled output holds the block in its result step until the register frees

`include "lis_length_patience_sort_assert.svh"

module lis_length_patience_sort #(
  parameter int MAX_LEN = lps_pkg::MaxLenDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  lps_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output lps_pkg::out_item_t out_item_o
);

  localparam int AddrW = $clog2(MAX_LEN);

  logic                       res_valid;
  logic                       res_busy;
  lps_pkg::out_item_t         res;
  logic                       ram_we;
  logic [AddrW-1:0]           ram_addr;
  logic [lps_pkg::ValueW-1:0] ram_wdata;
  logic [lps_pkg::ValueW-1:0] ram_rdata;

  logic                       out_valid_q;
  lps_pkg::out_item_t         out_item_q;

  // sorted tail store, one read or one write a cycle
  lps_tail_ram #(
    .Depth (MAX_LEN)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  // append / bisect / replace sequencer
  lps_ctrl #(
    .MaxLen (MAX_LEN)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .res_valid_o (res_valid),
    .res_busy_i  (res_busy),
    .res_o       (res),
    .ram_we_o    (ram_we),
    .ram_addr_o  (ram_addr),
    .ram_wdata_o (ram_wdata),
    .ram_rdata_i (ram_rdata)
  );

  // output register is busy only while it holds an item that is stalled
  assign res_busy = out_valid_q & out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid && !res_busy) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // payload only loads when the register is free
  always_ff @(posedge clk_i) begin
    if (res_valid && !res_busy) begin
      out_item_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // an accepted item blocks the input until its result is done
  `LPS_ASSERT_NEXT(a_one_at_a_time, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o, "item accepted while another is in progress")

  // overflow is only flagged with a full store
  `LPS_ASSERT_NOW(a_ovf_full, clk_i, rst_ni, out_valid_o && out_item_o.overflow, out_item_o.lis_length == lps_pkg::LisLenW'(MAX_LEN), "overflow reported below full length")

  // a new result never overwrites a stalled one
  `LPS_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && out_item_o == $past(out_item_o), "stalled result lost or changed")

endmodule

/* test/lps_check_pkg.sv */
`timescale 1ns / 1ps

package lps_check_pkg;

  import lps_pkg::*;

  class lis_scoreboard;
    // own copy of the tail store and its count
    logic signed [ValueW-1:0] tails [MaxLenDefault];
    int                       tail_count;
    bit                       overflow_flag;
    out_item_t                expected_results [$];

    int errors;
    int values_seen;
    int sequences_closed;
    int full_results;
    int longest;

    function new();
      tail_count       = 0;
      overflow_flag    = 1'b0;
      errors           = 0;
      values_seen      = 0;
      sequences_closed = 0;
      full_results     = 0;
      longest          = 0;
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    // works out the length answer for one accepted value
    function void note_value(in_item_t it);
      out_item_t exp;
      int        lo;
      int        hi;
      int        mid;
      if (tail_count == 0 || tails[tail_count-1] < it.value) begin
        if (tail_count < MaxLenDefault) begin
          tails[tail_count] = it.value;
          tail_count++;
        end else begin
          overflow_flag = 1'b1;
        end
      end else begin
        // lower bound: first tail not below the value
        lo = 0;
        hi = tail_count;
        while (lo < hi) begin
          mid = lo + (hi - lo) / 2;
          if (tails[mid] < it.value) lo = mid + 1;
          else hi = mid;
        end
        tails[lo] = it.value;
      end
      exp.lis_length = LisLenW'(tail_count);
      exp.overflow   = overflow_flag;
      exp.is_last    = it.last_item;
      expected_results.insert(expected_results.size(), exp);
      values_seen++;
      if (overflow_flag) full_results++;
      if (tail_count > longest) longest = tail_count;
      if (it.last_item) begin
        sequences_closed++;
        tail_count    = 0;
        overflow_flag = 1'b0;
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t exp;
      if (expected_results.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result: len %0d ovf %0b last %0b",
                   got.lis_length, got.overflow, got.is_last);
      end else begin
        exp = expected_results.pop_front();
        if (got.lis_length !== exp.lis_length || got.overflow !== exp.overflow ||
            got.is_last !== exp.is_last) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: exp len %0d ovf %0b last %0b, got len %0d ovf %0b last %0b",
                     exp.lis_length, exp.overflow, exp.is_last,
                     got.lis_length, got.overflow, got.is_last);
        end
      end
    endfunction
  endclass

endpackage

/* test/tb.sv */
`timescale 1ns / 1ps

module tb;

  import lps_pkg::*;
  import lps_check_pkg::*;

  // random part stops once this many values have gone in
  localparam int ItemTarget = 1750;
  // cycles with no item moving on either side before the run is abandoned
  localparam int StuckLimit = 4000;
  // long receiver hold-off, long enough to back the block up to its input
  localparam int HoldCycles = 300;
  // worst-case search latency plus margin, waited out at the end
  localparam int DrainCycles = 40;

  typedef enum int {SeqRandom, SeqNarrow, SeqRising, SeqExtreme} seq_kind_e;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_stall_o;
  in_item_t  in_item_i;
  logic      out_valid_o;
  logic      out_stall_i;
  out_item_t out_item_o;

  lis_scoreboard sb;

  int items_sent;
  int hold_reqs;    // bumped by the sender, served by the receiver
  bit tx_idle_on;
  int stuck;

  lis_length_patience_sort u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // offer one item, holding it until the block takes it at a rising edge
  task automatic send_item(input logic signed [ValueW-1:0] v, input logic last);
    in_item_t it;
    int       gap;
    it.value     = v;
    it.last_item = last;
    if ($urandom_range(0, 79) == 0) tx_idle_on = !tx_idle_on;
    gap = tx_idle_on ? $urandom_range(0, 16) : 0;
    if (gap > 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_value(it);
    items_sent++;
  endtask

  // sender goes quiet until every outstanding length has come back
  task automatic drain_results();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
  endtask

  // one long rising run that fills the whole tail store and then overflows;
  // every so often a value at or below the top lands on a replace instead
  task automatic send_full_store_run();
    longint                   level;
    longint                   lv;
    int                       appended;
    logic signed [ValueW-1:0] v;
    level    = -64'sd2147483648;
    appended = 0;
    while (appended < MaxLenDefault + 6) begin
      if (appended > 0 && $urandom_range(0, 7) == 0) begin
        lv = level - longint'($urandom_range(0, 50000));
        if (lv < -64'sd2147483648) lv = -64'sd2147483648;
        v = lv[ValueW-1:0];
      end else begin
        level += longint'($urandom_range(1, 2000000));
        v = level[ValueW-1:0];
        appended++;
      end
      send_item(v, 1'b0);
    end
    // a replace while the store is full, then close the sequence
    send_item(ValueW'(-2147483647), 1'b0);
    level += 1;
    send_item(level[ValueW-1:0], 1'b1);
  endtask

  task automatic send_sequence(input seq_kind_e kind, input int len);
    logic signed [ValueW-1:0] v;
    v = $urandom;
    for (int i = 0; i < len; i++) begin
      case (kind)
        SeqRandom: begin
          v = $urandom;
        end
        SeqNarrow: begin
          // tight range so equal values turn up often
          v = ValueW'($urandom_range(0, 16)) - ValueW'(8);
        end
        SeqRising: begin
          if ($urandom_range(0, 3) != 0) v = v + ValueW'($urandom_range(1, 100));
          else v = v - ValueW'($urandom_range(0, 200));
        end
        default: begin
          case ($urandom_range(0, 4))
            0: v = {1'b1, {(ValueW-1){1'b0}}};
            1: v = {1'b0, {(ValueW-1){1'b1}}};
            2: v = '0;
            3: v = '1;
            default: v = ValueW'(1);
          endcase
        end
      endcase
      send_item(v, i == len - 1);
    end
  endtask

  // receiver: draws a hold-off per result, and serves long hold requests by
  // counting the cycles itself
  initial begin
    int wait_left;
    int holds_served;
    bit rx_idle_on;
    out_stall_i  = 1'b0;
    wait_left    = 0;
    holds_served = 0;
    rx_idle_on   = 1'b1;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) begin
        sb.check_result(out_item_o);
        if ($urandom_range(0, 63) == 0) rx_idle_on = !rx_idle_on;
        wait_left = rx_idle_on ? $urandom_range(0, 16) : 0;
      end
      @(negedge clk_i);
      if (hold_reqs != holds_served) begin
        holds_served = hold_reqs;
        wait_left    = HoldCycles;
      end
      if (wait_left > 0) begin
        out_stall_i <= 1'b1;
        wait_left--;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // watchdog on cycles where no item moves on either channel
  always @(posedge clk_i) begin
    if (rst_ni && !((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)))
      stuck++;
    else
      stuck = 0;
    if (stuck >= StuckLimit) begin
      $display("tb: errors");
      $finish;
    end
  end

  initial begin
    seq_kind_e kind;
    int        len;
    sb         = new();
    items_sent = 0;
    hold_reqs  = 0;
    stuck      = 0;
    tx_idle_on = 1'b1;
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    in_item_i  = '0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // single-item sequence into an empty store
    send_item(32'sd0, 1'b1);
    // extremes, equal minimum, equal maximum at the top, crossing zero
    send_item({1'b0, {31{1'b1}}}, 1'b0);
    send_item({1'b1, {31{1'b0}}}, 1'b0);
    send_item({1'b1, {31{1'b0}}}, 1'b0);
    send_item(-32'sd1, 1'b0);
    send_item(32'sd0, 1'b0);
    send_item(32'sd1, 1'b0);
    send_item({1'b0, {31{1'b1}}}, 1'b0);
    send_item({1'b0, {31{1'b1}}}, 1'b0);
    send_item(32'sd5, 1'b1);
    // strictly falling run keeps the length at one
    send_item(32'sd10, 1'b0);
    send_item(32'sd9, 1'b0);
    send_item(32'sd8, 1'b0);
    send_item(32'sd7, 1'b1);
    // repeated value does not grow the length
    send_item(32'sd3, 1'b0);
    send_item(32'sd3, 1'b0);
    send_item(32'sd3, 1'b1);
    // lone extremes
    send_item({1'b1, {31{1'b0}}}, 1'b1);
    send_item({1'b0, {31{1'b1}}}, 1'b1);
    drain_results();

    // receiver holds off at the start of the long run so the block backs up
    hold_reqs++;
    send_full_store_run();
    drain_results();

    hold_reqs++;
    while (items_sent < ItemTarget) begin
      kind = seq_kind_e'($urandom_range(0, 3));
      len  = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 150) : $urandom_range(1, 24);
      send_sequence(kind, len);
    end

    drain_results();
    repeat (DrainCycles) @(negedge clk_i);

    $display("run covered %0d values over %0d sequences, longest store %0d",
             sb.values_seen, sb.sequences_closed, sb.longest);
    $display("%0d lengths given with the store full, %0d mismatches",
             sb.full_results, sb.errors);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+rtl
rtl/lps_pkg.sv
rtl/lps_tail_ram.sv
rtl/lps_ctrl.sv
rtl/lis_length_patience_sort.sv
test/lps_check_pkg.sv
test/tb.sv
